// File: rtl/core/distance_grid_bilinear_query_assert.svh
// Assertion macros for the distance grid query block.
// Used by the port checker; no other dependencies.
`ifndef DISTANCE_GRID_BILINEAR_QUERY_ASSERT_SVH
`define DISTANCE_GRID_BILINEAR_QUERY_ASSERT_SVH

// same-cycle implication, off during reset
`define DGBQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define DGBQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define DGBQ_ASSERT_ALW(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/dgbq_pkg.sv
// Shared types and constants for the distance grid query block.
// No dependencies.
`timescale 1ns / 1ps

package dgbq_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int QDEPTH    = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_RES  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd4;

    localparam logic [15:0] INV_RES_RST = 16'd256;
    localparam logic [6:0]  GRID_DIM_RST = 7'd64;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_QUERY,
        OP_MISS
    } t_op;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_LOAD,
        BS_READ,
        BS_MUL1,
        BS_MUL2,
        BS_DONE
    } t_bstate;

    typedef struct packed {
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic [15:0]        inv_resolution;
        logic [6:0]         grid_width;
        logic [6:0]         grid_height;
    } t_cfg;

endpackage

// File: rtl/core/dgbq_if.sv
// Request and result channel interfaces of the distance grid query block.
// No dependencies.
`timescale 1ns / 1ps

interface dgbq_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [5:0]         cell_x;
    logic [5:0]         cell_y;
    logic signed [15:0] cell_value;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;

    modport source (output valid, mode, cell_x, cell_y, cell_value, pos_x, pos_y,
                    input ready);
    modport sink   (input valid, mode, cell_x, cell_y, cell_value, pos_x, pos_y,
                    output ready);
endinterface

interface dgbq_out_if;
    logic               valid;
    logic               ready;
    logic               valid_res;
    logic signed [15:0] distance;
    logic signed [15:0] grad_x;
    logic signed [15:0] grad_y;

    modport source (output valid, valid_res, distance, grad_x, grad_y, input ready);
    modport sink   (input valid, valid_res, distance, grad_x, grad_y, output ready);
endinterface

// File: rtl/core/dgbq_front.sv
// Front end: takes requests, maps query positions to grid units and classifies.
// Depends on dgbq_pkg and dgbq_in_if.
`timescale 1ns / 1ps

module dgbq_front import dgbq_pkg::*; #(
    parameter int GRID_MAX  = 64,
    parameter int FRAC_BITS = 8,
    parameter int AW        = 12,
    parameter int EW        = 46
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    dgbq_in_if.sink        i_req,
    input  t_cfg           i_cfg,
    input  logic           i_full,
    output logic           o_push,
    output logic [EW-1:0]  o_ent
);

    localparam int F  = FRAC_BITS;
    localparam int UW = 34;
    localparam int XW = UW - 2 * F;
    localparam logic signed [UW-1:0] HALF = UW'(1) << (2 * F - 1);

    typedef struct packed {
        t_op                op;
        logic [AW-1:0]      addr;
        logic signed [15:0] wdata;
        logic [F-1:0]       a;
        logic [F-1:0]       b;
    } t_ent;

    logic               r_s1_vld, r_s2_vld;
    logic               r_s1_mode, r_s2_mode;
    logic [5:0]         r_s1_cx, r_s1_cy, r_s2_cx, r_s2_cy;
    logic signed [15:0] r_s1_val, r_s2_val;
    logic signed [16:0] r_s1_dx, r_s1_dy;
    logic signed [UW-1:0] r_s2_u, r_s2_v;

    logic               stall;
    logic signed [16:0] n_dx, n_dy;
    logic signed [UW-1:0] prod_x, prod_y;
    logic [XW-1:0]      x0, y0;
    logic [8:0]         w_eff, h_eff;
    logic               miss, keep;
    t_ent               ent;

    assign stall       = r_s2_vld && i_full;
    assign i_req.ready = !stall;

    assign n_dx = {i_req.pos_x[15], i_req.pos_x} - {i_cfg.origin_x[15], i_cfg.origin_x};
    assign n_dy = {i_req.pos_y[15], i_req.pos_y} - {i_cfg.origin_y[15], i_cfg.origin_y};

    assign prod_x = r_s1_dx * $signed({1'b0, i_cfg.inv_resolution});
    assign prod_y = r_s1_dy * $signed({1'b0, i_cfg.inv_resolution});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else if (!stall) begin
            r_s1_vld <= i_req.valid;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall) begin
            r_s1_mode <= i_req.mode;
            r_s1_cx   <= i_req.cell_x;
            r_s1_cy   <= i_req.cell_y;
            r_s1_val  <= i_req.cell_value;
            r_s1_dx   <= n_dx;
            r_s1_dy   <= n_dy;
            r_s2_mode <= r_s1_mode;
            r_s2_cx   <= r_s1_cx;
            r_s2_cy   <= r_s1_cy;
            r_s2_val  <= r_s1_val;
            r_s2_u    <= prod_x - HALF;
            r_s2_v    <= prod_y - HALF;
        end
    end

    // in-range test: u, v >= 0 and x0 + 1 < W, y0 + 1 < H
    always_comb begin
        x0    = r_s2_u[UW-1:2*F];
        y0    = r_s2_v[UW-1:2*F];
        w_eff = (32'(i_cfg.grid_width) < GRID_MAX) ? 9'(i_cfg.grid_width) : 9'(GRID_MAX);
        h_eff = (32'(i_cfg.grid_height) < GRID_MAX) ? 9'(i_cfg.grid_height) : 9'(GRID_MAX);
        miss  = r_s2_u[UW-1] || r_s2_v[UW-1]
             || (32'(x0) + 32'd1 >= 32'(w_eff))
             || (32'(y0) + 32'd1 >= 32'(h_eff));
        keep  = r_s2_mode || ((32'(r_s2_cx) < GRID_MAX) && (32'(r_s2_cy) < GRID_MAX));

        ent.wdata = r_s2_val;
        ent.a     = r_s2_u[2*F-1:F];
        ent.b     = r_s2_v[2*F-1:F];
        if (!r_s2_mode) begin
            ent.op   = OP_WRITE;
            ent.addr = AW'(32'(r_s2_cy) * GRID_MAX + 32'(r_s2_cx));
        end else begin
            ent.op   = miss ? OP_MISS : OP_QUERY;
            ent.addr = AW'(32'(y0) * GRID_MAX + 32'(x0));
        end
    end

    assign o_push = r_s2_vld && !i_full && keep;
    assign o_ent  = ent;

endmodule

// File: rtl/core/dgbq_fifo.sv
// Small queue between front and back ends.
// Depends on dgbq_pkg for the default depth QDEPTH.
`timescale 1ns / 1ps

module dgbq_fifo import dgbq_pkg::*; #(
    parameter int DW    = 46,
    parameter int DEPTH = QDEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    input  logic          i_pop,
    output logic [DW-1:0] o_data,
    output logic          o_full,
    output logic          o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DW-1:0] r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (32'(r_cnt) == DEPTH);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (32'(r_wp) == DEPTH - 1) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (32'(r_rp) == DEPTH - 1) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// File: rtl/core/dgbq_back.sv
// Back end: owns the distance memory, runs writes and bilinear queries.
// Depends on dgbq_pkg and dgbq_out_if.
`timescale 1ns / 1ps

module dgbq_back import dgbq_pkg::*; #(
    parameter int GRID_MAX  = 64,
    parameter int FRAC_BITS = 8,
    parameter int AW        = 12,
    parameter int EW        = 46
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  logic [EW-1:0] i_ent,
    output logic          o_pop,
    input  logic [15:0]   i_inv,
    dgbq_out_if.source    o_res
);

    localparam int F     = FRAC_BITS;
    localparam int DEPTH = GRID_MAX * GRID_MAX;
    localparam int TW    = F + 19;
    localparam int IW    = F + 21;
    localparam int DW    = TW + F + 3;
    localparam int GW    = IW + 17;
    localparam int RW    = (GW > DW) ? GW : DW;
    localparam logic signed [RW-1:0] RHALF = RW'(1) << (2 * F - 1);
    localparam logic signed [RW-1:0] SMAX  = RW'(32767);
    localparam logic signed [RW-1:0] SMIN  = -RW'(32768);

    typedef struct packed {
        t_op                op;
        logic [AW-1:0]      addr;
        logic signed [15:0] wdata;
        logic [F-1:0]       a;
        logic [F-1:0]       b;
    } t_ent;

    t_bstate            r_state, n_state;
    t_ent               r_ent;
    logic [2:0]         r_cnt;
    logic signed [15:0] r_mem [DEPTH];
    logic signed [15:0] r_rd;
    logic signed [15:0] r_v [4];
    logic signed [TW-1:0] r_t0, r_t1;
    logic signed [IW-1:0] r_ix, r_iy;
    logic signed [DW-1:0] r_dist;
    logic signed [GW-1:0] r_gx, r_gy;
    logic               r_out_vld, r_out_res;
    logic signed [15:0] r_out_dist, r_out_gx, r_out_gy;

    logic [AW-1:0]      mem_addr, off;
    logic               mem_we, slot_free;
    logic signed [F:0]  as, bs;
    logic signed [16:0] d0, d1, e0, e1;
    logic signed [F+17:0] pa0, pa1;
    logic signed [F+19:0] pb, pc;
    logic signed [TW:0]   td;
    logic signed [TW+F+1:0] pd;

    function automatic logic signed [15:0] sat_rnd(input logic signed [RW-1:0] x);
        logic signed [RW-1:0] s;
        s = (x + RHALF) >>> (2 * F);
        if (s > SMAX) begin
            return 16'sh7fff;
        end else if (s < SMIN) begin
            return 16'sh8000;
        end
        return s[15:0];
    endfunction

    assign slot_free = !r_out_vld || o_res.ready;
    assign o_pop     = (r_state == BS_IDLE) && !i_empty;

    // neighbor order: v00, v10, v01, v11
    always_comb begin
        unique case (r_cnt[1:0])
            2'd0:    off = AW'(0);
            2'd1:    off = AW'(1);
            2'd2:    off = AW'(GRID_MAX);
            default: off = AW'(GRID_MAX + 1);
        endcase
        mem_we   = (r_state == BS_LOAD) && (r_ent.op == OP_WRITE);
        mem_addr = mem_we ? r_ent.addr : r_ent.addr + off;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= r_ent.wdata;
        end
        r_rd <= r_mem[mem_addr];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: begin
                if (!i_empty) n_state = BS_LOAD;
            end
            BS_LOAD: begin
                unique case (r_ent.op)
                    OP_WRITE: n_state = BS_IDLE;
                    OP_QUERY: n_state = BS_READ;
                    default:  n_state = BS_DONE;
                endcase
            end
            BS_READ: begin
                if (r_cnt == 3'd4) n_state = BS_MUL1;
            end
            BS_MUL1: n_state = BS_MUL2;
            BS_MUL2: n_state = BS_DONE;
            BS_DONE: begin
                if (slot_free) n_state = BS_IDLE;
            end
            default: n_state = BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_ent;
        end
        if (r_state == BS_LOAD) begin
            r_cnt <= '0;
        end else if (r_state == BS_READ) begin
            r_cnt <= r_cnt + 3'd1;
            if (r_cnt != 3'd0) begin
                r_v[2'(r_cnt - 3'd1)] <= r_rd;
            end
        end
    end

    // first lerp along x, and inner gradient sums
    always_comb begin
        as  = $signed({1'b0, r_ent.a});
        bs  = $signed({1'b0, r_ent.b});
        d0  = r_v[1] - r_v[0];
        d1  = r_v[3] - r_v[2];
        e0  = r_v[2] - r_v[0];
        e1  = r_v[3] - r_v[1];
        pa0 = d0 * as;
        pa1 = d1 * as;
        pb  = (18'(d1) - 18'(d0)) * bs;
        pc  = (18'(e1) - 18'(e0)) * as;
        td  = (TW+1)'(r_t1) - (TW+1)'(r_t0);
        pd  = td * bs;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == BS_MUL1) begin
            r_t0 <= (TW'(r_v[0]) <<< F) + TW'(pa0);
            r_t1 <= (TW'(r_v[2]) <<< F) + TW'(pa1);
            r_ix <= (IW'(d0) <<< F) + IW'(pb);
            r_iy <= (IW'(e0) <<< F) + IW'(pc);
        end
        if (r_state == BS_MUL2) begin
            r_dist <= (DW'(r_t0) <<< F) + DW'(pd);
            r_gx   <= r_ix * $signed({1'b0, i_inv});
            r_gy   <= r_iy * $signed({1'b0, i_inv});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_state == BS_DONE && slot_free) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == BS_DONE && slot_free) begin
            if (r_ent.op == OP_QUERY) begin
                r_out_res  <= 1'b1;
                r_out_dist <= sat_rnd(RW'(r_dist));
                r_out_gx   <= sat_rnd(RW'(r_gx));
                r_out_gy   <= sat_rnd(RW'(r_gy));
            end else begin
                r_out_res  <= 1'b0;
                r_out_dist <= '0;
                r_out_gx   <= '0;
                r_out_gy   <= '0;
            end
        end
    end

    assign o_res.valid     = r_out_vld;
    assign o_res.valid_res = r_out_res;
    assign o_res.distance  = r_out_dist;
    assign o_res.grad_x    = r_out_gx;
    assign o_res.grad_y    = r_out_gy;

endmodule

// File: rtl/core/distance_grid_bilinear_query.sv
// Channel   Dir  Handshake       Payload
// i_req     in   valid/ready     mode, cell_x, cell_y, cell_value, pos_x, pos_y
// o_res     out  valid/ready     valid_res, distance, grad_x, grad_y
// i_cfg_*   in   write enable    register index, 16-bit data
// Front end: two register stages, one request per cycle while the queue has room.
// Back end: a write is done in LOAD; an in-range query makes four reads from the one
// single-port distance memory, two multiply stages, round and saturate; a miss skips to DONE.
// Synchronous active-low reset clears control; the memory holds garbage until written.
// A stalled result stays in the output register; the front keeps filling the queue.
`timescale 1ns / 1ps

module distance_grid_bilinear_query import dgbq_pkg::*; #(
    parameter int GRID_MAX  = 64,
    parameter int FRAC_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    dgbq_in_if.sink              i_req,
    dgbq_out_if.source           o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]          i_cfg_data
);

    localparam int AW = $clog2(GRID_MAX * GRID_MAX);
    localparam int EW = 2 + AW + 16 + 2 * FRAC_BITS;

    t_cfg          r_cfg;
    logic          push, pop, full, empty;
    logic [EW-1:0] push_ent, pop_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x       <= '0;
            r_cfg.origin_y       <= '0;
            r_cfg.inv_resolution <= INV_RES_RST;
            r_cfg.grid_width     <= GRID_DIM_RST;
            r_cfg.grid_height    <= GRID_DIM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ORIGIN_X: r_cfg.origin_x       <= i_cfg_data;
                CFG_ORIGIN_Y: r_cfg.origin_y       <= i_cfg_data;
                CFG_INV_RES:  r_cfg.inv_resolution <= i_cfg_data;
                CFG_WIDTH:    r_cfg.grid_width     <= i_cfg_data[6:0];
                CFG_HEIGHT:   r_cfg.grid_height    <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    dgbq_front #(
        .GRID_MAX(GRID_MAX), .FRAC_BITS(FRAC_BITS), .AW(AW), .EW(EW)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(i_req), .i_cfg(r_cfg),
        .i_full(full), .o_push(push), .o_ent(push_ent)
    );

    dgbq_fifo #(
        .DW(EW), .DEPTH(QDEPTH)
    ) u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_data(push_ent),
        .i_pop(pop), .o_data(pop_ent), .o_full(full), .o_empty(empty)
    );

    dgbq_back #(
        .GRID_MAX(GRID_MAX), .FRAC_BITS(FRAC_BITS), .AW(AW), .EW(EW)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(empty), .i_ent(pop_ent),
        .o_pop(pop), .i_inv(r_cfg.inv_resolution), .o_res(o_res)
    );

endmodule

// File: rtl/core/dgbq_checker.sv
// Port-level checker for the distance grid query block, bound to the top level.
// Depends on distance_grid_bilinear_query_assert.svh.
`timescale 1ns / 1ps
`include "distance_grid_bilinear_query_assert.svh"

module dgbq_port_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               i_ready,
    input logic               i_valid_res,
    input logic signed [15:0] i_distance,
    input logic signed [15:0] i_grad_x,
    input logic signed [15:0] i_grad_y
);

    `DGBQ_ASSERT_IMP(a_miss_zero, i_clk, i_rst_n, i_valid && !i_valid_res, i_distance == 16'sd0 && i_grad_x == 16'sd0 && i_grad_y == 16'sd0, "out-of-range result not zero")
    `DGBQ_ASSERT_NXT(a_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(i_valid_res) && $stable(i_distance) && $stable(i_grad_x) && $stable(i_grad_y), "stalled result changed")
    `DGBQ_ASSERT_ALW(a_rst_idle, i_clk, !i_rst_n, !i_valid, "result valid right after reset")

endmodule

bind distance_grid_bilinear_query dgbq_port_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(o_res.valid), .i_ready(o_res.ready),
    .i_valid_res(o_res.valid_res), .i_distance(o_res.distance),
    .i_grad_x(o_res.grad_x), .i_grad_y(o_res.grad_y)
);
